FILE: src/button_event_generator_unit_defines.svh
// Assertion macros for the RTL file that checks its own logic.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef BUTTON_EVENT_GENERATOR_UNIT_DEFINES_SVH
`define BUTTON_EVENT_GENERATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BEVG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BEVG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bevg_pkg.sv
`default_nettype none
package bevg_pkg;

  localparam int NUM_BUTTONS_DEF = 7;
  localparam int TIME_BITS_DEF   = 32;

  localparam int CMD_W      = 2;
  localparam int LEVEL_W    = 7;
  localparam int NOW_W      = 32;
  localparam int BUTTON_W   = 3;
  localparam int KIND_W     = 3;
  localparam int IDLE_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MASK_W     = 7;
  localparam int MS_W       = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_POLL     = 2'd0,
    CMD_RESYNC   = 2'd1,
    CMD_IDLE_RST = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_REPEAT  = 3'd2,
    EV_LONG    = 3'd3,
    EV_STATUS  = 3'd4
  } ev_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPEAT_MASK     = 2'd0,
    CFG_REPEAT_START    = 2'd1,
    CFG_REPEAT_INTERVAL = 2'd2,
    CFG_LONG_PRESS      = 2'd3
  } cfg_idx_t;

  localparam logic [MASK_W-1:0] REPEAT_MASK_RST     = 7'd15;
  localparam logic [MS_W-1:0]   REPEAT_START_RST    = 16'd500;
  localparam logic [MS_W-1:0]   REPEAT_INTERVAL_RST = 16'd150;
  localparam logic [MS_W-1:0]   LONG_PRESS_RST      = 16'd1000;

endpackage
`default_nettype wire

FILE: src/bevg_ifs.sv
`default_nettype none
interface bevg_in_if import bevg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [LEVEL_W-1:0] pressed;
  logic               debounce_pending;
  logic [NOW_W-1:0]   now_ms;

  modport source (output valid, cmd, pressed, debounce_pending, now_ms, input ready);
  modport sink   (input valid, cmd, pressed, debounce_pending, now_ms, output ready);
endinterface

interface bevg_out_if import bevg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BUTTON_W-1:0] button;
  logic [KIND_W-1:0]   event_kind;
  logic [IDLE_W-1:0]   idle_ms;
  logic                last;

  modport source (output valid, button, event_kind, idle_ms, last, input ready);
  modport sink   (input valid, button, event_kind, idle_ms, last, output ready);
endinterface
`default_nettype wire

FILE: src/button_event_generator_unit.sv
// Channel   Dir  Handshake     Payload
// in_item   in   valid/ready   cmd, pressed, debounce_pending, now_ms
// out_item  out  valid/ready   button, event_kind, idle_ms, last
// cfg       in   cfg_we        cfg_index, cfg_wdata
//
// The front takes one item per cycle while the two-entry queue has room.
// Each item leaves as 1 + E results, one per cycle while out_item.ready holds, E being
// the number of buttons with an event (0 to NUM_BUTTONS); the output serializer sets the rate.
// Synchronous reset clears all button state, the queue and the output valid flag.
// A stalled result holds in the output register; the queue then fills and
// in_item.ready drops.
`default_nettype none
`include "button_event_generator_unit_defines.svh"
module button_event_generator_unit import bevg_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bevg_in_if.sink                    in_item,
  bevg_out_if.source                 out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int REC_W = NUM_BUTTONS + NUM_BUTTONS * KIND_W + IDLE_W;

  logic                       push_valid;
  logic                       push_ready;
  logic [NUM_BUTTONS-1:0]     rec_ev;
  ev_kind_t [NUM_BUTTONS-1:0] rec_kind;
  logic [IDLE_W-1:0]          rec_idle;

  logic                       fifo_nonempty;
  logic                       fifo_pop;
  logic [REC_W-1:0]           head_data;
  logic [NUM_BUTTONS-1:0]     head_ev;
  ev_kind_t [NUM_BUTTONS-1:0] head_kind;
  logic [IDLE_W-1:0]          head_idle;

  bevg_front #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .TIME_BITS   (TIME_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .rec_ev     (rec_ev),
    .rec_kind   (rec_kind),
    .rec_idle   (rec_idle)
  );

  bevg_fifo #(
    .WIDTH (REC_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({rec_ev, rec_kind, rec_idle}),
    .pop_valid  (fifo_nonempty),
    .pop        (fifo_pop),
    .pop_data   (head_data)
  );

  assign {head_ev, head_kind, head_idle} = head_data;

  bevg_back #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (fifo_nonempty),
    .head_ev    (head_ev),
    .head_kind  (head_kind),
    .head_idle  (head_idle),
    .pop        (fifo_pop),
    .out_item   (out_item)
  );

  // Retiring a queue entry always loads that item's closing status result.
  `BEVG_ASSERT_NEXT(a_pop_loads_status, fifo_pop, out_item.valid && out_item.last, "pop without status result")
  // An accepted item sits in the queue on the following cycle at least.
  `BEVG_ASSERT_NEXT(a_accept_fills_queue, in_item.valid && in_item.ready, fifo_nonempty, "accepted item lost from queue")
  // The serializer only retires an entry that is present.
  `BEVG_ASSERT_SAME(a_pop_has_head, fifo_pop, fifo_nonempty, "pop from empty queue")

endmodule
`default_nettype wire

FILE: src/bevg_fifo.sv
`default_nettype none
module bevg_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: src/bevg_front.sv
`default_nettype none
module bevg_front import bevg_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bevg_in_if.sink                    in_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output logic [NUM_BUTTONS-1:0]     rec_ev,
  output ev_kind_t [NUM_BUTTONS-1:0] rec_kind,
  output logic [IDLE_W-1:0]          rec_idle
);

  logic [MASK_W-1:0] repeat_mask_r;
  logic [MS_W-1:0]   repeat_start_r;
  logic [MS_W-1:0]   repeat_interval_r;
  logic [MS_W-1:0]   long_press_r;

  logic [NUM_BUTTONS-1:0] prev_r, prev_nxt;
  logic [TIME_BITS-1:0]   pst_r [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   pst_nxt [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   lrt_r [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   lrt_nxt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] lf_r, lf_nxt;
  logic [TIME_BITS-1:0]   lat_r, lat_nxt;

  logic [TIME_BITS-1:0]   held [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   since [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   thr [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] ev;
  logic [NUM_BUTTONS-1:0] act;
  ev_kind_t               kind [NUM_BUTTONS];

  logic                   accept;
  cmd_t                   cmd;
  logic [TIME_BITS-1:0]   now_t;
  logic [NUM_BUTTONS-1:0] levels;
  logic [NUM_BUTTONS-1:0] rep_mask;
  logic                   is_poll;
  logic                   touch;

  assign accept         = in_item.valid && push_ready;
  assign in_item.ready  = push_ready;
  assign push_valid     = in_item.valid;
  assign cmd            = cmd_t'(in_item.cmd);
  assign now_t          = TIME_BITS'(in_item.now_ms);
  assign levels         = NUM_BUTTONS'(in_item.pressed);
  assign rep_mask       = NUM_BUTTONS'(repeat_mask_r);
  assign is_poll        = (cmd == CMD_POLL);

  // Each lane decides its own event; lanes share nothing but the config and the item's now_ms and debounce_pending.
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      held[i]    = now_t - pst_r[i];
      since[i]   = now_t - lrt_r[i];
      thr[i]     = (lrt_r[i] == pst_r[i]) ? TIME_BITS'(repeat_start_r)
                                          : TIME_BITS'(repeat_interval_r);
      ev[i]      = 1'b0;
      act[i]     = 1'b0;
      kind[i]    = EV_PRESS;
      pst_nxt[i] = pst_r[i];
      lrt_nxt[i] = lrt_r[i];
      lf_nxt[i]  = lf_r[i];
      if (levels[i] && !prev_r[i]) begin
        ev[i]      = 1'b1;
        act[i]     = 1'b1;
        kind[i]    = EV_PRESS;
        pst_nxt[i] = now_t;
        lrt_nxt[i] = now_t;
        lf_nxt[i]  = 1'b0;
      end else if (levels[i] && prev_r[i] && !in_item.debounce_pending) begin
        if (rep_mask[i]) begin
          if (since[i] >= thr[i]) begin
            ev[i]      = 1'b1;
            act[i]     = 1'b1;
            kind[i]    = EV_REPEAT;
            lrt_nxt[i] = now_t;
          end
        end else if (!lf_r[i] && (held[i] >= TIME_BITS'(long_press_r))) begin
          ev[i]     = 1'b1;
          kind[i]   = EV_LONG;
          lf_nxt[i] = 1'b1;
        end
      end else if (!levels[i] && prev_r[i]) begin
        ev[i]   = 1'b1;
        act[i]  = 1'b1;
        kind[i] = EV_RELEASE;
      end
      rec_kind[i] = kind[i];
    end
  end

  always_comb begin
    prev_nxt = prev_r;
    lat_nxt  = lat_r;
    touch    = 1'b0;
    unique case (cmd)
      CMD_POLL: begin
        prev_nxt = levels;
        touch    = |act;
      end
      CMD_RESYNC: begin
        prev_nxt = levels;
      end
      CMD_IDLE_RST: begin
        touch = 1'b1;
      end
      default: begin
      end
    endcase
    if (touch) begin
      lat_nxt = now_t;
    end
  end

  assign rec_ev = is_poll ? ev : '0;
  // Activity in this item moves the mark to now, which makes the idle time zero.
  assign rec_idle = touch ? '0 : IDLE_W'(now_t - lat_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      lf_r   <= '0;
      lat_r  <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        pst_r[i] <= '0;
        lrt_r[i] <= '0;
      end
    end else if (accept) begin
      prev_r <= prev_nxt;
      lat_r  <= lat_nxt;
      if (is_poll) begin
        lf_r <= lf_nxt;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          pst_r[i] <= pst_nxt[i];
          lrt_r[i] <= lrt_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_mask_r     <= REPEAT_MASK_RST;
      repeat_start_r    <= REPEAT_START_RST;
      repeat_interval_r <= REPEAT_INTERVAL_RST;
      long_press_r      <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REPEAT_MASK:     repeat_mask_r     <= cfg_wdata[MASK_W-1:0];
        CFG_REPEAT_START:    repeat_start_r    <= cfg_wdata;
        CFG_REPEAT_INTERVAL: repeat_interval_r <= cfg_wdata;
        CFG_LONG_PRESS:      long_press_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/bevg_back.sv
`default_nettype none
module bevg_back import bevg_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  head_valid,
  input  wire logic [NUM_BUTTONS-1:0] head_ev,
  input  wire ev_kind_t [NUM_BUTTONS-1:0] head_kind,
  input  wire logic [IDLE_W-1:0]     head_idle,
  output logic                       pop,
  bevg_out_if.source                 out_item
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic [NUM_BUTTONS-1:0] mask_r, mask_nxt;
  logic                   started_r, started_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [BUTTON_W-1:0]    button_r, button_nxt;
  ev_kind_t               kind_r, kind_nxt;
  logic [IDLE_W-1:0]      idle_r, idle_nxt;
  logic                   last_r, last_nxt;

  logic [NUM_BUTTONS-1:0] cur_mask;
  logic [NUM_BUTTONS-1:0] low_bit;
  logic [IDX_W-1:0]       sel_idx;
  logic                   load;

  // The first result of an item scans the queue head; later ones scan what is left.
  assign cur_mask = started_r ? mask_r : head_ev;
  assign low_bit  = cur_mask & (~cur_mask + 1'b1);
  assign load     = !out_valid_r || out_item.ready;

  always_comb begin
    sel_idx = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        sel_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    pop           = 1'b0;
    mask_nxt      = mask_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    button_nxt    = button_r;
    kind_nxt      = kind_r;
    idle_nxt      = idle_r;
    last_nxt      = last_r;
    if (load && head_valid) begin
      out_valid_nxt = 1'b1;
      if (|cur_mask) begin
        button_nxt  = BUTTON_W'(sel_idx);
        kind_nxt    = head_kind[sel_idx];
        idle_nxt    = '0;
        last_nxt    = 1'b0;
        mask_nxt    = cur_mask & ~low_bit;
        started_nxt = 1'b1;
      end else begin
        button_nxt  = '0;
        kind_nxt    = EV_STATUS;
        idle_nxt    = head_idle;
        last_nxt    = 1'b1;
        started_nxt = 1'b0;
        pop         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r   <= mask_nxt;
    button_r <= button_nxt;
    kind_r   <= kind_nxt;
    idle_r   <= idle_nxt;
    last_r   <= last_nxt;
  end

  assign out_item.valid      = out_valid_r;
  assign out_item.button     = button_r;
  assign out_item.event_kind = kind_r;
  assign out_item.idle_ms    = idle_r;
  assign out_item.last       = last_r;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import bevg_pkg::*;

  // Command code that the block leaves unused; it must give a bare status.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int NB = NUM_BUTTONS_DEF;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [LEVEL_W-1:0] pressed;
    logic               debounce;
    logic [NOW_W-1:0]   now;
    bit                 wait_drain;
  } poll_item_t;

  typedef struct {
    logic [BUTTON_W-1:0] button;
    ev_kind_t            kind;
    logic [IDLE_W-1:0]   idle;
    logic                last;
  } button_event_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bevg_in_if  in_if ();
  bevg_out_if out_if ();

  button_event_generator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_if),
    .out_item  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the block's button state and registers.
  logic [LEVEL_W-1:0] prev_lv;
  logic [NOW_W-1:0]   press_t [NB];
  logic [NOW_W-1:0]   rep_t [NB];
  logic               long_f [NB];
  logic [NOW_W-1:0]   act_t;
  logic [MASK_W-1:0]  rpt_mask;
  logic [MS_W-1:0]    rpt_start;
  logic [MS_W-1:0]    rpt_interval;
  logic [MS_W-1:0]    long_ms;

  poll_item_t    poll_q [$];
  button_event_t exp_events [$];
  poll_item_t    cur_poll;

  int  err_cnt = 0;
  int  polls_taken = 0;
  int  tx_gap = 0;
  int  rx_stall = 0;
  bit  in_took = 1'b0;
  bit  rx_long_hold = 1'b0;
  bit  long_hold_done = 1'b0;

  logic [LEVEL_W-1:0] gen_levels;
  logic [NOW_W-1:0]   gen_now;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic void queue_event(int btn, ev_kind_t k, logic [IDLE_W-1:0] idle,
                                      logic fin);
    button_event_t e;
    e.button = BUTTON_W'(btn);
    e.kind   = k;
    e.idle   = idle;
    e.last   = fin;
    exp_events.push_back(e);
  endfunction

  function automatic void predict_events(logic [CMD_W-1:0] op, logic [LEVEL_W-1:0] lv,
                                         logic deb, logic [NOW_W-1:0] now);
    logic [NOW_W-1:0] held;
    logic [NOW_W-1:0] since;
    logic [MS_W-1:0]  thr;
    if (op == CMD_POLL) begin
      for (int i = 0; i < NB; i++) begin
        if (lv[i] && !prev_lv[i]) begin
          press_t[i] = now;
          rep_t[i]   = now;
          long_f[i]  = 1'b0;
          act_t      = now;
          queue_event(i, EV_PRESS, '0, 1'b0);
        end else if (lv[i] && prev_lv[i] && !deb) begin
          held = now - press_t[i];
          if (rpt_mask[i]) begin
            since = now - rep_t[i];
            thr = (rep_t[i] == press_t[i]) ? rpt_start : rpt_interval;
            if (since >= {16'd0, thr}) begin
              rep_t[i] = now;
              act_t    = now;
              queue_event(i, EV_REPEAT, '0, 1'b0);
            end
          end else if (!long_f[i] && held >= {16'd0, long_ms}) begin
            long_f[i] = 1'b1;
            queue_event(i, EV_LONG, '0, 1'b0);
          end
        end else if (!lv[i] && prev_lv[i]) begin
          act_t = now;
          queue_event(i, EV_RELEASE, '0, 1'b0);
        end
      end
      prev_lv = lv;
    end else if (op == CMD_RESYNC) begin
      prev_lv = lv;
    end else if (op == CMD_IDLE_RST) begin
      act_t = now;
    end
    queue_event(0, EV_STATUS, now - act_t, 1'b1);
  endfunction

  // Sampling side: register writes, accepted polls and results, all at the rising edge.
  always @(posedge clk) begin
    button_event_t e;
    in_took = 1'b0;
    if (!rst_n) begin
      prev_lv      = '0;
      act_t        = '0;
      rpt_mask     = REPEAT_MASK_RST;
      rpt_start    = REPEAT_START_RST;
      rpt_interval = REPEAT_INTERVAL_RST;
      long_ms      = LONG_PRESS_RST;
      for (int i = 0; i < NB; i++) begin
        press_t[i] = '0;
        rep_t[i]   = '0;
        long_f[i]  = 1'b0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_REPEAT_MASK:     rpt_mask     = cfg_wdata[MASK_W-1:0];
          CFG_REPEAT_START:    rpt_start    = cfg_wdata;
          CFG_REPEAT_INTERVAL: rpt_interval = cfg_wdata;
          CFG_LONG_PRESS:      long_ms      = cfg_wdata;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        in_took = 1'b1;
        polls_taken++;
        predict_events(in_if.cmd, in_if.pressed, in_if.debounce_pending, in_if.now_ms);
      end
      if (out_if.valid && out_if.ready) begin
        if (exp_events.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: button=%0d kind=%0d idle=%0d last=%0b", $time,
                   out_if.button, out_if.event_kind, out_if.idle_ms, out_if.last);
        end else begin
          e = exp_events.pop_front();
          if (out_if.button !== e.button || out_if.event_kind !== e.kind ||
              out_if.idle_ms !== e.idle || out_if.last !== e.last) begin
            err_cnt++;
            $display("%0t: mismatch: expected button=%0d kind=%0d idle=%0d last=%0b", $time,
                     e.button, e.kind, e.idle, e.last);
            $display("%0t:           actual   button=%0d kind=%0d idle=%0d last=%0b", $time,
                     out_if.button, out_if.event_kind, out_if.idle_ms, out_if.last);
          end
        end
      end
    end
  end

  // Sender: offers the pending items with random gaps, holding each until it is taken.
  always @(negedge clk) begin
    if (rx_long_hold) tx_gap = 0;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_if.valid <= 1'b0;
      end else if (poll_q.size() > 0 && !(poll_q[0].wait_drain && exp_events.size() > 0)) begin
        cur_poll = poll_q.pop_front();
        in_if.cmd              <= cur_poll.cmd;
        in_if.pressed          <= cur_poll.pressed;
        in_if.debounce_pending <= cur_poll.debounce;
        in_if.now_ms           <= cur_poll.now;
        in_if.valid            <= 1'b1;
        tx_gap = rx_long_hold ? 0 : pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (!long_hold_done && polls_taken >= 60 && poll_q.size() >= 10) begin
        long_hold_done = 1'b1;
        rx_long_hold   = 1'b1;
        rx_stall       = 120;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_if.ready <= 1'b0;
      end else begin
        rx_long_hold = 1'b0;
        out_if.ready <= 1'b1;
        rx_stall = pick_gap();
      end
    end
  end

  task automatic add_poll(logic [CMD_W-1:0] op, logic [LEVEL_W-1:0] lv, logic deb,
                          logic [NOW_W-1:0] now, bit drain = 1'b0);
    poll_item_t p;
    p.cmd        = op;
    p.pressed    = lv;
    p.debounce   = deb;
    p.now        = now;
    p.wait_drain = drain;
    poll_q.push_back(p);
  endtask

  // Mostly plausible button activity with time moving forward, plus some noise.
  task automatic gen_random(int n, int big_pct);
    int r;
    logic [NOW_W-1:0] step;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        for (int b = 0; b < NB; b++) begin
          if ($urandom_range(0, 99) < 15) gen_levels[b] = ~gen_levels[b];
        end
        step = ($urandom_range(0, 99) < big_pct) ? $urandom : $urandom_range(0, 300);
        gen_now = gen_now + step;
        add_poll(CMD_POLL, gen_levels, $urandom_range(0, 99) < 20, gen_now,
                 $urandom_range(0, 99) < 4);
      end else if (r < 88) begin
        gen_now = gen_now + $urandom_range(0, 300);
        add_poll(CMD_RESYNC, LEVEL_W'($urandom), 1'($urandom), gen_now);
      end else if (r < 94) begin
        gen_now = gen_now + $urandom_range(0, 300);
        add_poll(CMD_IDLE_RST, LEVEL_W'($urandom), 1'($urandom), gen_now);
      end else begin
        add_poll(CMD_W'($urandom), LEVEL_W'($urandom), 1'($urandom), NOW_W'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    while (poll_q.size() > 0 || in_if.valid || exp_events.size() > 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic set_config(logic [MASK_W-1:0] mask, logic [MS_W-1:0] start,
                            logic [MS_W-1:0] interval, logic [MS_W-1:0] lp);
    write_reg(CFG_REPEAT_MASK, {9'd0, mask});
    write_reg(CFG_REPEAT_START, start);
    write_reg(CFG_REPEAT_INTERVAL, interval);
    write_reg(CFG_LONG_PRESS, lp);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_wdata              = '0;
    in_if.valid            = 1'b0;
    in_if.cmd              = '0;
    in_if.pressed          = '0;
    in_if.debounce_pending = 1'b0;
    in_if.now_ms           = '0;
    out_if.ready           = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings.
    add_poll(CMD_POLL, 7'h00, 1'b0, 32'd0);
    add_poll(CMD_POLL, 7'h7F, 1'b0, 32'd10);
    add_poll(CMD_POLL, 7'h7F, 1'b1, 32'd2000);
    add_poll(CMD_POLL, 7'h7F, 1'b0, 32'd2000);
    add_poll(CMD_POLL, 7'h7F, 1'b0, 32'd2100);
    add_poll(CMD_POLL, 7'h7F, 1'b0, 32'd2150);
    add_poll(CMD_POLL, 7'h00, 1'b0, 32'd2200, 1'b1);
    add_poll(CMD_RESYNC, 7'h7F, 1'b0, 32'd2300);
    add_poll(CMD_POLL, 7'h7F, 1'b0, 32'd2400);
    add_poll(CMD_POLL, 7'h2A, 1'b1, 32'd2500);
    add_poll(CMD_POLL, 7'h55, 1'b1, 32'd2600);
    add_poll(CMD_IDLE_RST, 7'h00, 1'b1, 32'd5000);
    add_poll(CMD_UNUSED, 7'h7F, 1'b1, 32'd6000);
    // Hold across the wrap of the millisecond counter.
    add_poll(CMD_POLL, 7'h00, 1'b0, 32'hFFFF_FF00);
    add_poll(CMD_POLL, 7'h41, 1'b0, 32'hFFFF_FFF0);
    add_poll(CMD_POLL, 7'h41, 1'b0, 32'h0000_0300);
    add_poll(CMD_POLL, 7'h41, 1'b0, 32'h0000_0500);
    add_poll(CMD_POLL, 7'h41, 1'b0, 32'h0000_0600);
    add_poll(CMD_UNUSED, 7'h7F, 1'b0, 32'hFFFF_FFFF);
    add_poll(CMD_IDLE_RST, 7'h55, 1'b0, 32'hFFFF_FFFF);
    add_poll(CMD_POLL, 7'h00, 1'b0, 32'h0000_0700);
    gen_levels = '0;
    gen_now    = 32'h0000_0700;
    wait_idle();

    set_config(7'h7F, 16'd0, 16'd0, 16'd0);
    gen_random(20, 5);
    wait_idle();

    set_config(7'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    gen_random(15, 40);
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      set_config(MASK_W'($urandom_range(0, 127)), MS_W'($urandom_range(0, 400)),
                 MS_W'($urandom_range(0, 200)), MS_W'($urandom_range(0, 600)));
      gen_random(13, 5);
      wait_idle();
    end

    set_config(REPEAT_MASK_RST, REPEAT_START_RST, REPEAT_INTERVAL_RST, LONG_PRESS_RST);
    gen_random(15, 10);
    wait_idle();

    repeat (20) @(posedge clk);
    if (exp_events.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected results never arrived", $time, exp_events.size());
    end
    if (err_cnt == 0) begin
      $display("button_event_generator_unit regression: pass");
    end else begin
      $display("button_event_generator_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, exp_events.size());
    $display("button_event_generator_unit regression: fail");
    $finish;
  end

endmodule
